FILE: design/exidx_range_lookup_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the exception-index range lookup
// Shared implication forms used by the RTL checks.
// ----------------------------------------------------------------------------
`ifndef EXIDX_RANGE_LOOKUP_ASSERT_SVH
`define EXIDX_RANGE_LOOKUP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define EXR_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("exr check failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define EXR_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("exr check failed: next-cycle implication");

`endif

FILE: design/exr_pkg.sv
// ----------------------------------------------------------------------------
// Exception-index lookup package
// Field widths, register indexes, request codes and shared structs.
// ----------------------------------------------------------------------------
package exr_pkg;

   localparam int ADDR_W      = 32;
   localparam int EIDX_W      = 10;
   localparam int CNT_W       = 11;
   localparam int TBL_IDX_W   = 16;
   localparam int CSR_IDX_W   = 1;
   localparam int ENTRY_SHIFT = 3;   // entries are 8 bytes apart

   localparam logic [ADDR_W-1:0] END_OF_TABLE = 32'h7FFF_FFFF;

   localparam logic [CSR_IDX_W-1:0] CSR_TABLE_BASE  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ENTRY_COUNT = 1'b1;

   localparam logic REQ_LOAD   = 1'b0;
   localparam logic REQ_LOOKUP = 1'b1;

   typedef struct packed {
      logic [ADDR_W-1:0] base;
      logic [CNT_W-1:0]  count;
   } cfg_type;

   typedef struct packed {
      logic                 wr_en;
      logic [TBL_IDX_W-1:0] wr_idx;
      logic [ADDR_W-1:0]    wr_data;
      logic                 rd_en;
      logic [TBL_IDX_W-1:0] rd_idx;
   } tbl_cmd_type;

   typedef struct packed {
      logic [ADDR_W-1:0] a;
      logic [ADDR_W-1:0] b;
   } alu_op_type;

   typedef struct packed {
      logic [ADDR_W-1:0] sum;
      logic              eq;
      logic              lt;
   } alu_res_type;

endpackage

FILE: design/exr_alu.sv
// ----------------------------------------------------------------------------
// Shared add / compare unit
// One 32-bit adder and one unsigned comparator, time-shared by the sequencer.
// ----------------------------------------------------------------------------
module exr_alu (
   input  exr_pkg::alu_op_type  op,
   output exr_pkg::alu_res_type res
);
   import exr_pkg::*;

   always_comb begin
      res.sum = op.a + op.b;
      res.eq  = (op.a == op.b);
      res.lt  = (op.a < op.b);
   end

endmodule

FILE: design/exr_table.sv
// ----------------------------------------------------------------------------
// Start-address table
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module exr_table #(
   parameter int DEPTH = 1024
) (
   input  logic                        clock,
   input  exr_pkg::tbl_cmd_type        cmd,
   output logic [exr_pkg::ADDR_W-1:0]  rd_data
);
   import exr_pkg::*;

   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [ADDR_W-1:0] mem [DEPTH];
   logic [ADDR_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.wr_idx[IW-1:0]] <= cmd.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_data_ff <= mem[cmd.rd_idx[IW-1:0]];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/exr_ctrl.sv
// ----------------------------------------------------------------------------
// Lookup sequencer
// Drives loads and the binary search through the shared unit and the table.
// ----------------------------------------------------------------------------
`include "exidx_range_lookup_assert.svh"

module exr_ctrl #(
   parameter int MAX_ENTRIES = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_type,
   input  logic [exr_pkg::EIDX_W-1:0]    req_entry_index,
   input  logic [exr_pkg::ADDR_W-1:0]    req_entry_word,
   input  logic [exr_pkg::ADDR_W-1:0]    req_pc,
   input  exr_pkg::cfg_type              cfg,
   output exr_pkg::tbl_cmd_type          tbl_cmd,
   input  logic [exr_pkg::ADDR_W-1:0]    tbl_rd_data,
   output exr_pkg::alu_op_type           alu_op,
   input  exr_pkg::alu_res_type          alu_res,
   output logic                          rsp_strobe,
   output logic                          rsp_found,
   output logic [exr_pkg::ADDR_W-1:0]    rsp_entry_address,
   output logic [exr_pkg::ADDR_W-1:0]    rsp_range_start,
   output logic [exr_pkg::ADDR_W-1:0]    rsp_range_end
);
   import exr_pkg::*;

   localparam int IW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CW   = $clog2(MAX_ENTRIES + 1);
   localparam int CMPW = (CW > CNT_W) ? CW : CNT_W;

   typedef enum logic [7:0] {
      S_IDLE     = 8'b0000_0001,
      S_LD_ADDR  = 8'b0000_0010,
      S_LD_WRITE = 8'b0000_0100,
      S_LK_INIT  = 8'b0000_1000,
      S_SEARCH   = 8'b0001_0000,
      S_START    = 8'b0010_0000,
      S_END      = 8'b0100_0000,
      S_RESP     = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   logic              type_ff,  type_in;
   logic [EIDX_W-1:0] eidx_ff,  eidx_in;
   logic [ADDR_W-1:0] word_ff,  word_in;
   logic [ADDR_W-1:0] pc_ff,    pc_in;
   logic [CW-1:0]     lo_ff,    lo_in;
   logic [CW-1:0]     hi_ff,    hi_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [IW-1:0]     mid_ff,   mid_in;
   logic [IW-1:0]     pick_ff,  pick_in;
   logic              nxt_ok_ff, nxt_ok_in;
   logic              found_ff, found_in;
   logic [ADDR_W-1:0] addr_ff,  addr_in;
   logic [ADDR_W-1:0] start_ff, start_in;
   logic [ADDR_W-1:0] end_ff,   end_in;

   logic [CW-1:0]     cnt_eff;
   logic [CW-1:0]     nlo;
   logic [CW-1:0]     nhi;
   logic [CW:0]       lh_sum;
   logic [CW-1:0]     nxt_idx;
   logic              idx_ok;

   // Clamp the programmed count to the table depth.
   always_comb begin
      if (CMPW'(cfg.count) > CMPW'(MAX_ENTRIES)) begin
         cnt_eff = CW'(MAX_ENTRIES);
      end else begin
         cnt_eff = CW'(cfg.count);
      end
   end

   // Narrow the search window from the probe compare.
   always_comb begin
      if (alu_res.lt) begin
         nlo = lo_ff;
         nhi = CW'(mid_ff);
      end else begin
         nlo = CW'(mid_ff) + CW'(1);
         nhi = hi_ff;
      end
      lh_sum  = {1'b0, nlo} + {1'b0, nhi};
      nxt_idx = CW'(pick_ff) + CW'(1);
      idx_ok  = 32'(eidx_ff) < 32'(MAX_ENTRIES);
   end

   always_comb begin
      state_in  = state_ff;
      type_in   = type_ff;
      eidx_in   = eidx_ff;
      word_in   = word_ff;
      pc_in     = pc_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      count_in  = count_ff;
      mid_in    = mid_ff;
      pick_in   = pick_ff;
      nxt_ok_in = nxt_ok_ff;
      found_in  = found_ff;
      addr_in   = addr_ff;
      start_in  = start_ff;
      end_in    = end_ff;

      alu_op.a  = pc_ff;
      alu_op.b  = tbl_rd_data;

      tbl_cmd         = '0;
      tbl_cmd.wr_idx  = TBL_IDX_W'(eidx_ff);
      tbl_cmd.wr_data = alu_res.sum;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               type_in = req_type;
               eidx_in = req_entry_index;
               word_in = req_entry_word;
               pc_in   = req_pc;
               state_in = (req_type == REQ_LOOKUP) ? S_LK_INIT : S_LD_ADDR;
            end
         end
         S_LD_ADDR: begin
            alu_op.a = cfg.base;
            alu_op.b = ADDR_W'(eidx_ff) << ENTRY_SHIFT;
            addr_in  = alu_res.sum;
            state_in = S_LD_WRITE;
         end
         S_LD_WRITE: begin
            alu_op.a      = addr_ff;
            alu_op.b      = {word_ff[ADDR_W-2], word_ff[ADDR_W-2:0]};
            tbl_cmd.wr_en = idx_ok;
            state_in      = S_IDLE;
         end
         S_LK_INIT: begin
            count_in = cnt_eff;
            if (cfg.base == '0 || cnt_eff == '0) begin
               found_in = 1'b0;
               addr_in  = '0;
               start_in = '0;
               end_in   = '0;
               state_in = S_RESP;
            end else begin
               lo_in          = '0;
               hi_in          = cnt_eff;
               mid_in         = IW'(cnt_eff >> 1);
               tbl_cmd.rd_en  = 1'b1;
               tbl_cmd.rd_idx = TBL_IDX_W'(mid_in);
               state_in       = S_SEARCH;
            end
         end
         S_SEARCH: begin
            if (alu_res.eq) begin
               pick_in        = mid_ff;
               tbl_cmd.rd_en  = 1'b1;
               tbl_cmd.rd_idx = TBL_IDX_W'(mid_ff);
               state_in       = S_START;
            end else if (nlo < nhi) begin
               lo_in          = nlo;
               hi_in          = nhi;
               mid_in         = IW'(lh_sum >> 1);
               tbl_cmd.rd_en  = 1'b1;
               tbl_cmd.rd_idx = TBL_IDX_W'(mid_in);
            end else if (nhi == '0) begin
               found_in = 1'b0;
               addr_in  = '0;
               start_in = '0;
               end_in   = '0;
               state_in = S_RESP;
            end else begin
               pick_in        = IW'(nhi - CW'(1));
               tbl_cmd.rd_en  = 1'b1;
               tbl_cmd.rd_idx = TBL_IDX_W'(pick_in);
               state_in       = S_START;
            end
         end
         S_START: begin
            start_in       = tbl_rd_data;
            nxt_ok_in      = nxt_idx < count_ff;
            tbl_cmd.rd_en  = nxt_ok_in;
            tbl_cmd.rd_idx = TBL_IDX_W'(nxt_idx);
            state_in       = S_END;
         end
         S_END: begin
            end_in   = nxt_ok_ff ? tbl_rd_data : END_OF_TABLE;
            alu_op.a = cfg.base;
            alu_op.b = ADDR_W'(pick_ff) << ENTRY_SHIFT;
            addr_in  = alu_res.sum;
            found_in = 1'b1;
            state_in = S_RESP;
         end
         S_RESP: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      type_ff   <= type_in;
      eidx_ff   <= eidx_in;
      word_ff   <= word_in;
      pc_ff     <= pc_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      count_ff  <= count_in;
      mid_ff    <= mid_in;
      pick_ff   <= pick_in;
      nxt_ok_ff <= nxt_ok_in;
      found_ff  <= found_in;
      addr_ff   <= addr_in;
      start_ff  <= start_in;
      end_ff    <= end_in;
   end

   assign busy              = (state_ff != S_IDLE);
   assign rsp_strobe        = (state_ff == S_RESP) && (type_ff == REQ_LOOKUP);
   assign rsp_found         = found_ff;
   assign rsp_entry_address = addr_ff;
   assign rsp_range_start   = start_ff;
   assign rsp_range_end     = end_ff;

   `EXR_ASSERT_IMP(a_search_window, clock, reset, state_ff == S_SEARCH,
                   (lo_ff < hi_ff) && (CW'(mid_ff) >= lo_ff) &&
                   (CW'(mid_ff) < hi_ff) && (hi_ff <= count_ff))
   `EXR_ASSERT_IMP(a_pick_range, clock, reset, state_ff == S_START, CW'(pick_ff) < count_ff)
   `EXR_ASSERT_IMP(a_miss_zero, clock, reset, rsp_strobe && !rsp_found,
                   (addr_ff == '0) && (start_ff == '0) && (end_ff == '0))
   `EXR_ASSERT_IMP(a_write_alone, clock, reset, tbl_cmd.wr_en,
                   (state_ff == S_LD_WRITE) && !tbl_cmd.rd_en)
   `EXR_ASSERT_NXT(a_resp_once, clock, reset, state_ff == S_RESP, state_ff == S_IDLE)

endmodule

FILE: design/exidx_range_lookup.sv
// ----------------------------------------------------------------------------
// Exception-index range lookup
// Sorted start-address table with a binary search for the covering entry.
// ----------------------------------------------------------------------------
// A load word (req_type 0) decodes entry_word as a 31-bit self-relative offset,
// sign-extends it, adds it to the entry address (table_base + index * 8) and
// stores the absolute start; it returns no result. A lookup word (req_type 1)
// searches the first entry_count entries for the last start at or below req_pc
// and returns one result word: found, the entry address, its start and the
// next entry's start (0x7FFFFFFF for the last entry). All result fields are
// zero on a miss: zero base, empty table or pc below the first entry. Each
// probe reads the single table read port once, and a lookup makes at most
// floor(log2(count)) + 1 probes (11 for 1024 entries); a zero base or zero
// count answers without reading the table. busy stays high until the result
// cycle has ended. rsp_strobe is high for exactly one cycle to mark the result
// on the rsp_ ports; the receiver cannot stall it, so capture it then.
// Configuration writes are always accepted (csr_ready is tied high) and must
// only be issued while busy is low. Table entries hold no reset value: a lookup
// must only touch entries that were loaded.
// ----------------------------------------------------------------------------
module exidx_range_lookup #(
   parameter int MAX_ENTRIES = 1024
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             start,
   output logic                             busy,
   input  logic                             req_type,
   input  logic [exr_pkg::EIDX_W-1:0]       req_entry_index,
   input  logic [exr_pkg::ADDR_W-1:0]       req_entry_word,
   input  logic [exr_pkg::ADDR_W-1:0]       req_pc,
   // result channel
   output logic                             rsp_strobe,
   output logic                             rsp_found,
   output logic [exr_pkg::ADDR_W-1:0]       rsp_entry_address,
   output logic [exr_pkg::ADDR_W-1:0]       rsp_range_start,
   output logic [exr_pkg::ADDR_W-1:0]       rsp_range_end,
   // configuration channel
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [exr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [exr_pkg::ADDR_W-1:0]       csr_data
);
   import exr_pkg::*;

   logic [ADDR_W-1:0] base_ff,  base_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   cfg_type           cfg;
   tbl_cmd_type       tbl_cmd;
   logic [ADDR_W-1:0] tbl_rd_data;
   alu_op_type        alu_op;
   alu_res_type       alu_res;

   // Register writes take effect in the cycle after csr_valid; no back-pressure.
   assign csr_ready = 1'b1;

   always_comb begin
      base_in  = base_ff;
      count_in = count_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_TABLE_BASE:  base_in  = csr_data;
            CSR_ENTRY_COUNT: count_in = csr_data[CNT_W-1:0];
            default: begin
               base_in  = base_ff;
               count_in = count_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= '0;
         count_ff <= '0;
      end else begin
         base_ff  <= base_in;
         count_ff <= count_in;
      end
   end

   assign cfg.base  = base_ff;
   assign cfg.count = count_ff;

   // Sequencer: owns the search window and result registers.
   exr_ctrl #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_type          (req_type),
      .req_entry_index   (req_entry_index),
      .req_entry_word    (req_entry_word),
      .req_pc            (req_pc),
      .cfg               (cfg),
      .tbl_cmd           (tbl_cmd),
      .tbl_rd_data       (tbl_rd_data),
      .alu_op            (alu_op),
      .alu_res           (alu_res),
      .rsp_strobe        (rsp_strobe),
      .rsp_found         (rsp_found),
      .rsp_entry_address (rsp_entry_address),
      .rsp_range_start   (rsp_range_start),
      .rsp_range_end     (rsp_range_end)
   );

   // Shared adder and comparator: address math on loads and results,
   // pc-versus-start compare on every probe.
   exr_alu u_alu (
      .op  (alu_op),
      .res (alu_res)
   );

   // Start-address store, one read and one write per cycle.
   exr_table #(
      .DEPTH (MAX_ENTRIES)
   ) u_table (
      .clock   (clock),
      .cmd     (tbl_cmd),
      .rd_data (tbl_rd_data)
   );

endmodule
